>>> hdl/omc_pkg.sv
// shared codes, widths and register reset values of the one-wire bus master
package omc_pkg;

  // field widths
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LongW   = 10;
  localparam int unsigned ShortW  = 8;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned BitsW   = 4;
  localparam int unsigned CfgIdxW = 3;

  // request function codes, also used as operation codes
  localparam logic [FuncW-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_RESET = 3'd1;
  localparam logic [FuncW-1:0] FUNC_WBIT  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_RBIT  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_WBYTE = 3'd4;
  localparam logic [FuncW-1:0] FUNC_RBYTE = 3'd5;

  // operation held while idle
  localparam logic [FuncW-1:0] OP_IDLE = FUNC_TICK;

  // slot phases
  localparam logic [PhaseW-1:0] PH_LOW  = 2'd0;
  localparam logic [PhaseW-1:0] PH_WAIT = 2'd1;
  localparam logic [PhaseW-1:0] PH_REC  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRES_WAIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_REC  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WZERO_LOW  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DLY = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_LEN   = 3'd6;

  // standard slot timings in microseconds
  localparam logic [LongW-1:0]  RST_RESET_LOW  = 10'd480;
  localparam logic [LongW-1:0]  RST_PRES_WAIT  = 10'd70;
  localparam logic [LongW-1:0]  RST_RESET_REC  = 10'd410;
  localparam logic [ShortW-1:0] RST_SHORT_LOW  = 8'd6;
  localparam logic [ShortW-1:0] RST_WZERO_LOW  = 8'd60;
  localparam logic [ShortW-1:0] RST_SAMPLE_DLY = 8'd9;
  localparam logic [ShortW-1:0] RST_SLOT_LEN   = 8'd70;

  // bit counts of the two transfer sizes
  localparam logic [BitsW-1:0] BITS_BYTE = 4'd8;
  localparam logic [BitsW-1:0] BITS_ONE  = 4'd1;

endpackage

>>> hdl/onewire_master_controller.sv
// one-wire bus master: slot timing sequencer with configurable timings
//
// Each request is a command or a tick: a command starts an operation, a tick
// request advances bus time by one microsecond and carries the sampled line
// level. The slot state (operation, phase, microsecond counter, shift data,
// bit count) is updated by a single pass of counter and compare logic, and
// the status for that request lands in a result register in the cycle after
// acceptance. A new request is taken every cycle while the result register
// is empty or being drained, so the sustained rate is one request per cycle;
// bus timing is set entirely by the number of tick requests, e.g. a reset
// with the default timings spans 960 ticks and a bit slot 70 ticks.
module onewire_master_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [omc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [omc_pkg::LongW-1:0]      cfg_data_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [omc_pkg::FuncW-1:0]      func_i,
  input  logic [omc_pkg::ByteW-1:0]      data_byte_i,
  input  logic                           line_level_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           pull_low_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic                           presence_o,
  output logic [omc_pkg::ByteW-1:0]      read_data_o,
  output logic                           rejected_o
);
  import omc_pkg::*;

  // configuration registers
  logic [LongW-1:0]  reset_low_q, pres_wait_q, reset_rec_q;
  logic [ShortW-1:0] short_low_q, wzero_low_q, sample_dly_q, slot_len_q;

  // slot state
  logic [FuncW-1:0]  op_q, op_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [LongW-1:0]  tcount_q, tcount_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic [BitsW-1:0]  bits_q, bits_d;
  logic              pres_q, pres_d;

  // result register
  logic              out_valid_q;
  logic              pull_low_q, busy_q, done_q, pres_out_q, rej_q;
  logic              rej_d, done_d;
  logic [ByteW-1:0]  rdata_q, rdata_d;

  logic              in_fire;
  logic              is_cmd, is_wr, is_rd;
  logic [LongW-1:0]  tc_inc, low_len, wait_len, rec_len;
  logic [ShortW:0]   used;
  logic [BitsW-1:0]  bits_dec;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q  <= RST_RESET_LOW;
      pres_wait_q  <= RST_PRES_WAIT;
      reset_rec_q  <= RST_RESET_REC;
      short_low_q  <= RST_SHORT_LOW;
      wzero_low_q  <= RST_WZERO_LOW;
      sample_dly_q <= RST_SAMPLE_DLY;
      slot_len_q   <= RST_SLOT_LEN;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RESET_LOW:  reset_low_q  <= cfg_data_i;
        CFG_PRES_WAIT:  pres_wait_q  <= cfg_data_i;
        CFG_RESET_REC:  reset_rec_q  <= cfg_data_i;
        CFG_SHORT_LOW:  short_low_q  <= cfg_data_i[ShortW-1:0];
        CFG_WZERO_LOW:  wzero_low_q  <= cfg_data_i[ShortW-1:0];
        CFG_SAMPLE_DLY: sample_dly_q <= cfg_data_i[ShortW-1:0];
        CFG_SLOT_LEN:   slot_len_q   <= cfg_data_i[ShortW-1:0];
        default: ;
      endcase
    end
  end

  // operation class and phase lengths
  assign is_wr  = (op_q == FUNC_WBIT) || (op_q == FUNC_WBYTE);
  assign is_rd  = (op_q == FUNC_RBIT) || (op_q == FUNC_RBYTE);
  assign is_cmd = (func_i >= FUNC_RESET) && (func_i <= FUNC_RBYTE);
  assign tc_inc = tcount_q + LongW'(1);
  assign bits_dec = bits_q - BitsW'(1);

  always_comb begin
    if (op_q == FUNC_RESET) begin
      low_len = reset_low_q;
    end else if (is_wr && !shift_q[0]) begin
      low_len = LongW'(wzero_low_q);
    end else begin
      low_len = LongW'(short_low_q);
    end
  end

  assign wait_len = (op_q == FUNC_RESET) ? pres_wait_q : LongW'(sample_dly_q);

  // recovery fills the rest of a bit slot, at least one microsecond; a reset uses its own recovery time
  always_comb begin
    if (is_wr) begin
      used = (ShortW+1)'(low_len[ShortW-1:0]);
    end else begin
      used = (ShortW+1)'(short_low_q) + (ShortW+1)'(sample_dly_q);
    end
    if (op_q == FUNC_RESET) begin
      rec_len = reset_rec_q;
    end else if ((ShortW+1)'(slot_len_q) > used) begin
      rec_len = LongW'((ShortW+1)'(slot_len_q) - used);
    end else begin
      rec_len = LongW'(1);
    end
  end

  // next slot state and result of one request
  always_comb begin
    op_d     = op_q;
    phase_d  = phase_q;
    tcount_d = tcount_q;
    shift_d  = shift_q;
    bits_d   = bits_q;
    pres_d   = pres_q;
    rej_d    = 1'b0;
    done_d   = 1'b0;
    rdata_d  = '0;
    if (is_cmd) begin
      if (op_q != OP_IDLE) begin
        rej_d = 1'b1;
      end else begin
        op_d     = func_i;
        phase_d  = PH_LOW;
        tcount_d = '0;
        bits_d   = ((func_i == FUNC_WBYTE) || (func_i == FUNC_RBYTE)) ? BITS_BYTE : BITS_ONE;
        if (func_i == FUNC_WBIT) begin
          shift_d = ByteW'(data_byte_i[0]);
        end else if (func_i == FUNC_WBYTE) begin
          shift_d = data_byte_i;
        end else begin
          shift_d = '0;
        end
      end
    end else if (op_q != OP_IDLE) begin
      tcount_d = tc_inc;
      priority if (phase_q == PH_LOW) begin
        if (tc_inc >= low_len) begin
          tcount_d = '0;
          phase_d  = is_wr ? PH_REC : PH_WAIT;
        end
      end else if (phase_q == PH_WAIT) begin
        if (tc_inc >= wait_len) begin
          if (op_q == FUNC_RESET) begin
            pres_d = !line_level_i;
          end else if (op_q == FUNC_RBIT) begin
            shift_d = ByteW'(line_level_i);
          end else begin
            shift_d = {line_level_i, shift_q[ByteW-1:1]};
          end
          tcount_d = '0;
          phase_d  = PH_REC;
        end
      end else begin
        if (tc_inc >= rec_len) begin
          tcount_d = '0;
          phase_d  = PH_LOW;
          bits_d   = bits_dec;
          if (is_wr) begin
            shift_d = shift_q >> 1;
          end
          if ((bits_dec == '0) || (op_q == FUNC_RESET)) begin
            done_d  = 1'b1;
            rdata_d = is_rd ? shift_q : '0;
            op_d    = OP_IDLE;
            bits_d  = '0;
          end
        end
      end
    end
  end

  // slot state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_IDLE;
      phase_q  <= PH_LOW;
      tcount_q <= '0;
      shift_q  <= '0;
      bits_q   <= '0;
      pres_q   <= 1'b0;
    end else if (in_fire) begin
      op_q     <= op_d;
      phase_q  <= phase_d;
      tcount_q <= tcount_d;
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      pres_q   <= pres_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pull_low_q <= (op_d != OP_IDLE) && (phase_d == PH_LOW);
      busy_q     <= (op_d != OP_IDLE);
      done_q     <= done_d;
      pres_out_q <= pres_d;
      rdata_q    <= rdata_d;
      rej_q      <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pull_low_o  = pull_low_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign presence_o  = pres_out_q;
  assign read_data_o = rdata_q;
  assign rejected_o  = rej_q;

endmodule
